// File: rtl/core/stack_machine_executor_defines.svh
// Assertion macros used by the stack machine executor.
`ifndef STACK_MACHINE_EXECUTOR_DEFINES_SVH
`define STACK_MACHINE_EXECUTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SME_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SME_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/sme_pkg.sv
package sme_pkg;

    localparam int DEFAULT_STACK_DEPTH = 64;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 3;

    localparam logic [OP_W-1:0] OP_PUSH      = 3'd0;
    localparam logic [OP_W-1:0] OP_PRINT_ALL = 3'd1;
    localparam logic [OP_W-1:0] OP_PRINT_TOP = 3'd2;
    localparam logic [OP_W-1:0] OP_POP       = 3'd3;
    localparam logic [OP_W-1:0] OP_SWAP      = 3'd4;
    localparam logic [OP_W-1:0] OP_ADD       = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ARG    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PINT_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SWAP_SHORT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ADD_SHORT  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_FULL       = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PR_RD,
        S_RD_B,
        S_WR_A,
        S_WR_B,
        S_OUT
    } t_state;

endpackage

// File: rtl/core/stack_machine_executor.sv
// Stack machine executor: runs push, print all, print top, pop, swap, add and nop
// on a circular store of signed 32-bit words.
// The input channel is i_valid with o_stall; a transfer happens at a rising edge
// where i_valid is high and o_stall is low. The result channel is o_valid with
// i_stall, and each result carries data, has_value, status and last.
// The user writes the queue mode register through i_cfg_we and i_cfg_data
// only while idle; the block itself does not enforce this. One instruction is
// handled at a time, and o_stall stays high until its final result has been
// transferred. Push, pop, nop, print all on an empty store and all error cases
// go from S_EXEC straight to S_OUT; print top first reads in S_PR_RD, add
// passes S_RD_B and S_WR_A, and swap passes S_RD_B, S_WR_A and S_WR_B. Print all
// on a non-empty store passes S_EXEC, S_PR_RD and S_OUT once per stored entry.
// The storage array gives one registered read and one write per cycle to the
// shared adder and sequencer.
// A stall on the result side holds the result register and the sequencer.
// Synchronous reset empties the store, selects stack mode, and returns to idle;
// the storage array itself is not cleared.
`include "stack_machine_executor_defines.svh"

module stack_machine_executor #(
    parameter int STACK_DEPTH = sme_pkg::DEFAULT_STACK_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic                                i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [sme_pkg::OP_W-1:0]            i_op,
    input  logic signed [sme_pkg::DATA_W-1:0]   i_value,
    input  logic                                i_value_ok,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [sme_pkg::DATA_W-1:0]   o_data,
    output logic                                o_has_value,
    output logic [sme_pkg::STATUS_W-1:0]        o_status,
    output logic                                o_last
);
    import sme_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int SW = CW + 1;

    t_state r_state, n_state;

    logic [DATA_W-1:0]   r_mem [STACK_DEPTH];
    logic [DATA_W-1:0]   r_rd_data;

    logic                r_queue_mode;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_top, n_top;
    logic [CW-1:0]       r_k, n_k;
    logic [OP_W-1:0]     r_op, n_op;
    logic [DATA_W-1:0]   r_value, n_value;
    logic                r_value_ok, n_value_ok;
    logic [DATA_W-1:0]   r_tmp, n_tmp;
    logic [DATA_W-1:0]   r_out_data, n_out_data;
    logic                r_out_has, n_out_has;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    logic [CW-1:0]       w_k;
    logic [SW-1:0]       w_sum;
    logic [SW-1:0]       w_wrap;
    logic [AW-1:0]       w_slot;
    logic [AW-1:0]       w_top_dec;
    logic                w_full;
    logic                w_short;
    logic                w_we;
    logic [AW-1:0]       w_wr_addr;
    logic [DATA_W-1:0]   w_wr_data;

    assign w_sum     = SW'(r_top) + SW'(w_k);
    assign w_wrap    = (w_sum >= SW'(STACK_DEPTH)) ? (w_sum - SW'(STACK_DEPTH)) : w_sum;
    assign w_slot    = w_wrap[AW-1:0];
    assign w_top_dec = (r_top == '0) ? AW'(STACK_DEPTH - 1) : (r_top - 1'b1);
    assign w_full    = (r_count >= CW'(STACK_DEPTH));
    assign w_short   = (r_count < CW'(2));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_op)
                    OP_PRINT_ALL, OP_PRINT_TOP: begin
                        n_state = (r_count == '0) ? S_OUT : S_PR_RD;
                    end
                    OP_SWAP, OP_ADD: begin
                        n_state = w_short ? S_OUT : S_RD_B;
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_PR_RD: n_state = S_OUT;
            S_RD_B:  n_state = S_WR_A;
            S_WR_A:  n_state = (r_op == OP_SWAP) ? S_WR_B : S_OUT;
            S_WR_B:  n_state = S_OUT;
            S_OUT: begin
                if (!i_stall) begin
                    n_state = r_out_last ? S_IDLE : S_EXEC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = (r_state != S_IDLE);
        o_valid     = (r_state == S_OUT);
        o_data      = r_out_data;
        o_has_value = r_out_has;
        o_status    = r_out_status;
        o_last      = r_out_last;
        w_k         = r_k;
        w_we        = 1'b0;
        w_wr_addr   = w_slot;
        w_wr_data   = r_tmp;
        case (r_state)
            S_EXEC: begin
                if (r_op == OP_PUSH) begin
                    w_k       = r_count;
                    w_we      = r_value_ok && !w_full;
                    w_wr_addr = r_queue_mode ? w_slot : w_top_dec;
                    w_wr_data = r_value;
                end else if (r_op == OP_POP) begin
                    w_k = CW'(1);
                end
            end
            S_WR_A: begin
                w_we      = 1'b1;
                w_wr_data = (r_op == OP_ADD) ? (r_rd_data + r_tmp) : r_tmp;
            end
            S_WR_B: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_top        = r_top;
        n_k          = r_k;
        n_op         = r_op;
        n_value      = r_value;
        n_value_ok   = r_value_ok;
        n_tmp        = r_tmp;
        n_out_data   = r_out_data;
        n_out_has    = r_out_has;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op       = i_op;
                    n_value    = i_value;
                    n_value_ok = i_value_ok;
                    n_k        = '0;
                end
            end
            S_EXEC: begin
                n_out_data   = '0;
                n_out_has    = 1'b0;
                n_out_status = ST_OK;
                n_out_last   = 1'b1;
                case (r_op)
                    OP_PUSH: begin
                        if (!r_value_ok) begin
                            n_out_status = ST_BAD_ARG;
                        end else if (w_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                            if (!r_queue_mode) begin
                                n_top = w_top_dec;
                            end
                        end
                    end
                    OP_PRINT_TOP: begin
                        if (r_count == '0) begin
                            n_out_status = ST_PINT_EMPTY;
                        end
                    end
                    OP_POP: begin
                        if (r_count == '0) begin
                            n_out_status = ST_POP_EMPTY;
                        end else begin
                            n_top   = w_slot;
                            n_count = r_count - 1'b1;
                        end
                    end
                    OP_SWAP: begin
                        if (w_short) begin
                            n_out_status = ST_SWAP_SHORT;
                        end else begin
                            n_k = CW'(1);
                        end
                    end
                    OP_ADD: begin
                        if (w_short) begin
                            n_out_status = ST_ADD_SHORT;
                        end else begin
                            n_k = CW'(1);
                        end
                    end
                    default: begin
                        n_out_status = ST_OK;
                    end
                endcase
            end
            S_PR_RD: begin
                n_out_data   = r_rd_data;
                n_out_has    = 1'b1;
                n_out_status = ST_OK;
                n_out_last   = (r_op == OP_PRINT_ALL) ? ((r_k + 1'b1) == r_count) : 1'b1;
            end
            S_RD_B: begin
                n_tmp = r_rd_data;
            end
            S_WR_A: begin
                n_tmp = r_rd_data;
                n_k   = '0;
                if (r_op == OP_ADD) begin
                    n_top   = w_slot;
                    n_count = r_count - 1'b1;
                end
            end
            S_OUT: begin
                if (!i_stall && !r_out_last) begin
                    n_k = r_k + 1'b1;
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        r_rd_data <= r_mem[w_slot];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_queue_mode <= 1'b0;
            r_count      <= '0;
            r_top        <= '0;
            r_k          <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_queue_mode <= i_cfg_data;
            end
            r_count <= n_count;
            r_top   <= n_top;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_value      <= n_value;
        r_value_ok   <= n_value_ok;
        r_tmp        <= n_tmp;
        r_out_data   <= n_out_data;
        r_out_has    <= n_out_has;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    `SME_ASSERT_NOW(a_count_bound, r_state == S_IDLE, r_count <= CW'(STACK_DEPTH), "Count overflow.")
    `SME_ASSERT_NOW(a_value_ok_status, o_valid && o_has_value, o_status == ST_OK, "Entry with error.")
    `SME_ASSERT_NEXT(a_last_to_idle, o_valid && !i_stall && o_last, r_state == S_IDLE, "Not idle.")
    `SME_ASSERT_NEXT(a_idle_count_hold, r_state == S_IDLE, r_count == $past(r_count), "Count moved.")

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import sme_pkg::*;

    localparam int DEPTH = DEFAULT_STACK_DEPTH;
    localparam int SLOT_W = $clog2(DEPTH);
    localparam logic [OP_W-1:0] OP_NOP = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE = 3'd7;
    localparam logic signed [DATA_W-1:0] MAX_WORD = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] MIN_WORD = 32'sh80000000;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 20;
    localparam int RANDOM_PHASES = 2;
    localparam int PHASE_ITEMS = 10;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic                     value_ok;
    } instr_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] data;
        logic                     has_value;
        logic [STATUS_W-1:0]      status;
        logic                     last;
    } result_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic                     cfg_data = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [OP_W-1:0]          in_op = OP_NOP;
    logic signed [DATA_W-1:0] in_value = '0;
    logic                     in_value_ok = 1'b0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [DATA_W-1:0] out_data;
    logic                     out_has_value;
    logic [STATUS_W-1:0]      out_status;
    logic                     out_last;

    instr_t  pending_instrs[$];
    result_t expected_results[$];

    logic signed [DATA_W-1:0] sm_words [DEPTH];
    logic [SLOT_W-1:0]        sm_top = '0;
    int                       sm_count = 0;
    logic                     sm_queue_mode = 1'b0;

    bit instr_taken = 1'b0;
    int burst_left = 4;
    int gap_left = 0;
    int stall_mode = 0;
    int fail_count = 0;
    int cycle_count = 0;

    stack_machine_executor i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_op        (in_op),
        .i_value     (in_value),
        .i_value_ok  (in_value_ok),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_data      (out_data),
        .o_has_value (out_has_value),
        .o_status    (out_status),
        .o_last      (out_last)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endfunction

    function automatic void expect_result(logic signed [DATA_W-1:0] data, logic has_value,
                                          logic [STATUS_W-1:0] status, logic last);
        result_t r;
        r.data = data;
        r.has_value = has_value;
        r.status = status;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic void predict_results(instr_t in);
        logic [SLOT_W-1:0]        second;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] held;
        second = sm_top + 1'b1;
        case (in.op)
            OP_PUSH: begin
                if (!in.value_ok) begin
                    expect_result('0, 1'b0, ST_BAD_ARG, 1'b1);
                end else if (sm_count >= DEPTH) begin
                    expect_result('0, 1'b0, ST_FULL, 1'b1);
                end else begin
                    if (sm_queue_mode) begin
                        slot = sm_top + SLOT_W'(sm_count);
                        sm_words[slot] = in.value;
                    end else begin
                        sm_top = sm_top - 1'b1;
                        sm_words[sm_top] = in.value;
                    end
                    sm_count++;
                    expect_result('0, 1'b0, ST_OK, 1'b1);
                end
            end
            OP_PRINT_ALL: begin
                if (sm_count == 0) begin
                    expect_result('0, 1'b0, ST_OK, 1'b1);
                end else begin
                    for (int k = 0; k < sm_count; k++) begin
                        slot = sm_top + SLOT_W'(k);
                        expect_result(sm_words[slot], 1'b1, ST_OK, k == sm_count - 1);
                    end
                end
            end
            OP_PRINT_TOP: begin
                if (sm_count == 0) begin
                    expect_result('0, 1'b0, ST_PINT_EMPTY, 1'b1);
                end else begin
                    expect_result(sm_words[sm_top], 1'b1, ST_OK, 1'b1);
                end
            end
            OP_POP: begin
                if (sm_count == 0) begin
                    expect_result('0, 1'b0, ST_POP_EMPTY, 1'b1);
                end else begin
                    sm_top = second;
                    sm_count--;
                    expect_result('0, 1'b0, ST_OK, 1'b1);
                end
            end
            OP_SWAP: begin
                if (sm_count < 2) begin
                    expect_result('0, 1'b0, ST_SWAP_SHORT, 1'b1);
                end else begin
                    held = sm_words[sm_top];
                    sm_words[sm_top] = sm_words[second];
                    sm_words[second] = held;
                    expect_result('0, 1'b0, ST_OK, 1'b1);
                end
            end
            OP_ADD: begin
                if (sm_count < 2) begin
                    expect_result('0, 1'b0, ST_ADD_SHORT, 1'b1);
                end else begin
                    sm_words[second] = sm_words[second] + sm_words[sm_top];
                    sm_top = second;
                    sm_count--;
                    expect_result('0, 1'b0, ST_OK, 1'b1);
                end
            end
            default: begin
                expect_result('0, 1'b0, ST_OK, 1'b1);
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return MAX_WORD;
            1: return MIN_WORD;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic instr_t rand_instr();
        instr_t it;
        int     pick;
        pick = $urandom_range(0, 99);
        it.value = rand_word();
        it.value_ok = 1'($urandom_range(0, 1));
        if (pick < 38) begin
            it.op = OP_PUSH;
            it.value_ok = ($urandom_range(0, 11) != 0);
        end else if (pick < 58) begin
            it.op = OP_POP;
        end else if (pick < 68) begin
            it.op = OP_PRINT_TOP;
        end else if (pick < 77) begin
            it.op = OP_SWAP;
        end else if (pick < 87) begin
            it.op = OP_ADD;
        end else if (pick < 93) begin
            it.op = OP_PRINT_ALL;
        end else begin
            it.op = $urandom_range(0, 1) ? OP_NOP : OP_SPARE;
        end
        return it;
    endfunction

    function automatic void queue_instr(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                                        logic value_ok);
        instr_t it;
        it.op = op;
        it.value = value;
        it.value_ok = value_ok;
        pending_instrs.push_back(it);
    endfunction

    task automatic write_mode(logic mode);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        sm_queue_mode = mode;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (pending_instrs.size() != 0 || in_valid || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    always @(negedge clk) begin
        instr_t nxt;
        if (rst_n && (!in_valid || instr_taken)) begin
            instr_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_instrs.size() > 0) begin
                nxt = pending_instrs.pop_front();
                in_op <= nxt.op;
                in_value <= nxt.value;
                in_value_ok <= nxt.value_ok;
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if ($urandom_range(0, 99) == 0) begin
            stall_mode = $urandom_range(0, 2);
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    always @(posedge clk) begin
        result_t want;
        instr_t  taken;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    note_failure($sformatf({"unexpected result data=%0d has_value=%0b ",
                                            "status=%0d last=%0b"},
                                           out_data, out_has_value, out_status, out_last));
                end else begin
                    want = expected_results.pop_front();
                    if (out_data !== want.data || out_has_value !== want.has_value ||
                        out_status !== want.status || out_last !== want.last) begin
                        note_failure($sformatf({"expected data=%0d has_value=%0b status=%0d ",
                                                "last=%0b, got data=%0d has_value=%0b ",
                                                "status=%0d last=%0b"},
                                               want.data, want.has_value, want.status, want.last,
                                               out_data, out_has_value, out_status, out_last));
                    end
                end
            end
            if (in_valid && !in_stall) begin
                taken.op = in_op;
                taken.value = in_value;
                taken.value_ok = in_value_ok;
                predict_results(taken);
                instr_taken = 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("stack_machine_executor test failed");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_mode(1'b0);
        queue_instr(OP_PRINT_TOP, '0, 1'b1);
        queue_instr(OP_PRINT_ALL, '0, 1'b1);
        queue_instr(OP_POP, '0, 1'b1);
        queue_instr(OP_SWAP, '0, 1'b1);
        queue_instr(OP_ADD, '0, 1'b1);
        queue_instr(OP_PUSH, MIN_WORD, 1'b0);
        queue_instr(OP_PUSH, MAX_WORD, 1'b1);
        queue_instr(OP_SWAP, '0, 1'b1);
        queue_instr(OP_ADD, '0, 1'b1);
        queue_instr(OP_PUSH, MIN_WORD, 1'b1);
        queue_instr(OP_PRINT_ALL, '0, 1'b1);
        queue_instr(OP_SWAP, '0, 1'b1);
        queue_instr(OP_PRINT_ALL, '0, 1'b1);
        queue_instr(OP_ADD, '0, 1'b1);
        queue_instr(OP_PRINT_TOP, '0, 1'b1);
        queue_instr(OP_PUSH, MAX_WORD, 1'b1);
        queue_instr(OP_PUSH, 32'sd1, 1'b1);
        queue_instr(OP_ADD, '1, 1'b0);
        queue_instr(OP_PRINT_ALL, '0, 1'b1);
        queue_instr(OP_NOP, MAX_WORD, 1'b0);
        queue_instr(OP_SPARE, MIN_WORD, 1'b1);
        queue_instr(OP_POP, '0, 1'b1);
        queue_instr(OP_POP, '0, 1'b1);
        queue_instr(OP_POP, '0, 1'b1);
        queue_instr(OP_PRINT_ALL, '0, 1'b1);
        wait_idle();

        write_mode(1'b1);
        for (int i = 0; i < DEPTH; i++) begin
            queue_instr(OP_PUSH, rand_word(), 1'b1);
        end
        queue_instr(OP_PUSH, rand_word(), 1'b1);
        queue_instr(OP_PUSH, rand_word(), 1'b0);
        queue_instr(OP_PRINT_ALL, '0, 1'b1);
        queue_instr(OP_SWAP, '0, 1'b1);
        queue_instr(OP_ADD, '0, 1'b1);
        queue_instr(OP_PRINT_TOP, '0, 1'b1);
        wait_idle();

        write_mode(1'b0);
        queue_instr(OP_PUSH, rand_word(), 1'b1);
        queue_instr(OP_PUSH, rand_word(), 1'b1);
        queue_instr(OP_PRINT_TOP, '0, 1'b1);
        for (int i = 0; i <= DEPTH; i++) begin
            queue_instr(OP_POP, rand_word(), 1'($urandom_range(0, 1)));
        end
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            write_mode(phase % 2 == 0);
            repeat (PHASE_ITEMS) pending_instrs.push_back(rand_instr());
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        fail_count += expected_results.size();
        if (fail_count == 0) begin
            $display("stack_machine_executor test passed");
        end else begin
            $display("stack_machine_executor test failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sme_pkg.sv
rtl/core/stack_machine_executor.sv
verif/tb_top.sv
